/* sv/kth_smallest_max_heap_core_defines.svh */
// Assertion macros shared by the kth-smallest heap core.
`ifndef KTH_SMALLEST_MAX_HEAP_CORE_DEFINES_SVH
`define KTH_SMALLEST_MAX_HEAP_CORE_DEFINES_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define KSMH_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the core clock and reset.
`define KSMH_ASSERT(lbl, prop, msg) \
  `KSMH_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* sv/ksmh_pkg.sv */
// Shared constants and controller/datapath interface types for the heap core.
`default_nettype none

package ksmh_pkg;

  localparam int K_MAX_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int K_RANK_W = 7;
  localparam logic [K_RANK_W-1:0] K_RANK_RST = K_RANK_W'(1);

  // Register map: one 32-bit register, index taken from paddr[2].
  localparam int ADDR_W = 3;
  localparam logic REG_K_RANK = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UP_RD  = 6'b000010,
    ST_UP_CMP = 6'b000100,
    ST_DN_RD  = 6'b001000,
    ST_DN_CMP = 6'b010000,
    ST_FIN    = 6'b100000
  } ksmh_state_e;

  // Controller -> datapath.
  typedef struct packed {
    logic load;    // input beat taken
    logic up_rd;   // sift-up: read parent or drop value at root
    logic up_cmp;  // sift-up: compare with parent, move hole
    logic dn_rd;   // sift-down: read children or drop value at leaf
    logic dn_cmp;  // sift-down: pick larger child, move hole
    logic emit;    // load output register, restart set
  } ksmh_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic need_insert; // heap not yet holding k entries
    logic lt_root;     // incoming value below current root
    logic pos_zero;    // hole at root
    logic up_stop;     // parent >= value
    logic leaf;        // hole has no child inside the heap
    logic dn_stop;     // no child larger than value
    logic last;        // item closes the set
    logic out_free;    // output register can take a beat
  } ksmh_status_t;

endpackage

`default_nettype wire

/* sv/ksmh_ctrl.sv */
// Control FSM for the heap core: sequences insert, replace and result steps.
`default_nettype none

module ksmh_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ksmh_pkg::ksmh_status_t status_i,
  output ksmh_pkg::ksmh_cmd_t        cmd_o
);

  ksmh_pkg::ksmh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksmh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ksmh_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ksmh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.need_insert) begin
            state_d = ksmh_pkg::ST_UP_RD;
          end else if (status_i.lt_root) begin
            state_d = ksmh_pkg::ST_DN_RD;
          end else begin
            state_d = ksmh_pkg::ST_FIN;
          end
        end
      end
      ksmh_pkg::ST_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d = status_i.pos_zero ? ksmh_pkg::ST_FIN : ksmh_pkg::ST_UP_CMP;
      end
      ksmh_pkg::ST_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d = status_i.up_stop ? ksmh_pkg::ST_FIN : ksmh_pkg::ST_UP_RD;
      end
      ksmh_pkg::ST_DN_RD: begin
        cmd_o.dn_rd = 1'b1;
        state_d = status_i.leaf ? ksmh_pkg::ST_FIN : ksmh_pkg::ST_DN_CMP;
      end
      ksmh_pkg::ST_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d = status_i.dn_stop ? ksmh_pkg::ST_FIN : ksmh_pkg::ST_DN_RD;
      end
      ksmh_pkg::ST_FIN: begin
        if (!status_i.last) begin
          state_d = ksmh_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ksmh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ksmh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/ksmh_dp.sv */
// Heap datapath: heap memory, hole position, compares and output register.
`default_nettype none

module ksmh_dp #(
  parameter int K_MAX      = ksmh_pkg::K_MAX_DEF,
  parameter int DATA_WIDTH = ksmh_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ksmh_pkg::K_RANK_W-1:0] k_rank_i,
  input  wire logic signed [DATA_WIDTH-1:0]  in_value_i,
  input  wire logic                          in_last_i,
  input  wire ksmh_pkg::ksmh_cmd_t           cmd_i,
  output ksmh_pkg::ksmh_status_t             status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]       out_kth_o,
  output logic                               out_vres_o
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int FW = $clog2(K_MAX + 1);
  localparam int IW = AW + 2;

  logic signed [DATA_WIDTH-1:0] heap_mem [K_MAX];

  logic signed [DATA_WIDTH-1:0] v_q, root_q, rd_a_q, rd_b_q, kth_q;
  logic                         last_q, vres_q, out_valid_q;
  logic [AW-1:0]                pos_q;
  logic [FW-1:0]                fill_q, size_q;

  logic [FW-1:0]                k_eff;
  logic [AW-1:0]                par_idx, rd_addr_a;
  logic [IW-1:0]                l_idx, r_idx, size_ext;
  logic                         r_in, sel_l, sel_r, dn_stop, up_stop, leaf, need_insert;
  logic signed [DATA_WIDTH-1:0] big_lv, child_val;
  logic [AW-1:0]                child_idx;
  logic                         wr_en, out_free;
  logic signed [DATA_WIDTH-1:0] wr_data;

  // Rank clamp: zero acts as one, above capacity acts as capacity.
  always_comb begin
    if (k_rank_i == '0) begin
      k_eff = FW'(1);
    end else if (int'(k_rank_i) > K_MAX) begin
      k_eff = FW'(K_MAX);
    end else begin
      k_eff = FW'(k_rank_i);
    end
  end

  assign need_insert = (fill_q < k_eff);
  assign par_idx     = (pos_q - AW'(1)) >> 1;
  assign l_idx       = {1'b0, pos_q, 1'b1};
  assign r_idx       = l_idx + IW'(1);
  assign size_ext    = IW'(size_q);
  assign leaf        = (l_idx >= size_ext);
  assign r_in        = (r_idx < size_ext);

  assign up_stop   = (rd_a_q >= v_q);
  assign sel_l     = (rd_a_q > v_q);
  assign big_lv    = sel_l ? rd_a_q : v_q;
  assign sel_r     = r_in && (rd_b_q > big_lv);
  assign dn_stop   = !sel_l && !sel_r;
  assign child_val = sel_r ? rd_b_q : rd_a_q;
  assign child_idx = sel_r ? r_idx[AW-1:0] : l_idx[AW-1:0];

  assign rd_addr_a = cmd_i.up_rd ? par_idx : l_idx[AW-1:0];
  assign out_free  = !out_valid_q || out_ready_i;

  // Hole-based sifts: the moving value is written once, where it settles.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = v_q;
    if (cmd_i.up_rd && (pos_q == '0)) begin
      wr_en = 1'b1;
    end
    if (cmd_i.up_cmp) begin
      wr_en   = 1'b1;
      wr_data = up_stop ? v_q : rd_a_q;
    end
    if (cmd_i.dn_rd && leaf) begin
      wr_en = 1'b1;
    end
    if (cmd_i.dn_cmp) begin
      wr_en   = 1'b1;
      wr_data = dn_stop ? v_q : child_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[pos_q] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_addr_a];
    rd_b_q <= heap_mem[r_idx[AW-1:0]];
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en && (pos_q == '0)) begin
      root_q <= wr_data;
    end
    if (cmd_i.load) begin
      v_q    <= in_value_i;
      last_q <= in_last_i;
      size_q <= k_eff;
      pos_q  <= need_insert ? fill_q[AW-1:0] : '0;
    end else if (cmd_i.up_cmp && !up_stop) begin
      pos_q <= par_idx;
    end else if (cmd_i.dn_cmp && !dn_stop) begin
      pos_q <= child_idx;
    end
    if (cmd_i.emit) begin
      kth_q  <= (fill_q >= k_eff) ? root_q : '0;
      vres_q <= (fill_q >= k_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        fill_q <= '0;
      end else if (cmd_i.load && need_insert) begin
        fill_q <= fill_q + FW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.need_insert = need_insert;
    status_o.lt_root     = (in_value_i < root_q);
    status_o.pos_zero    = (pos_q == '0);
    status_o.up_stop     = up_stop;
    status_o.leaf        = leaf;
    status_o.dn_stop     = dn_stop;
    status_o.last        = last_q;
    status_o.out_free    = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_kth_o   = kth_q;
  assign out_vres_o  = vres_q;

endmodule

`default_nettype wire

/* sv/kth_smallest_max_heap_core.sv */
// Kth-smallest selector: bounded max-heap of the k smallest values of a set.
// Input stream: one signed value per beat, tlast marks the final value of a set.
// Output stream: one beat per set, sent after the tlast beat; tdata carries the
//   kth smallest value, tuser is 1 when the set held at least k values (else
//   tdata is zero).
// APB register 0 (k_rank, 7 bits, reset 1) sets k; 0 acts as 1, values above
//   K_MAX act as K_MAX. Write it only between sets while the core is idle.
// Heap access: the heap memory has one write and two read ports with registered
//   read data, so each heap level takes a read step and a compare/move step.
//   An insert climbs toward the root, and a replacement of the root sinks toward
//   a leaf, by at most log2(k) levels; a value not below the root skips heap work.
//   One beat is in flight at a time.
// Result: when the tlast beat's heap work ends, the FIN step loads the output
//   register once it is free, and the output beat is driven from that register.
// Reset clears the fill count, FSM and output valid; heap contents are left
//   as is and are never read before being written in the current set.
// Output stall: the result sits in the output register; the core keeps taking
//   values of the next set and only waits if that set ends before the beat
//   is taken.
`default_nettype none
`include "kth_smallest_max_heap_core_defines.svh"

module kth_smallest_max_heap_core #(
  parameter int K_MAX      = ksmh_pkg::K_MAX_DEF,
  parameter int DATA_WIDTH = ksmh_pkg::DATA_WIDTH_DEF,
  localparam int TDW       = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ksmh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // Input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [TDW-1:0]              s_axis_tdata,  // [DATA_WIDTH-1:0] value
  input  wire logic                        s_axis_tlast,
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [TDW-1:0]                   m_axis_tdata,  // [DATA_WIDTH-1:0] kth_value
  output logic                             m_axis_tuser   // [0] valid_res
);

  logic [ksmh_pkg::K_RANK_W-1:0] k_rank_q;
  logic                          reg_idx, cfg_wr;

  ksmh_pkg::ksmh_cmd_t           cmd;
  ksmh_pkg::ksmh_status_t        status;
  logic signed [DATA_WIDTH-1:0]  in_value, out_kth;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_rank_q <= ksmh_pkg::K_RANK_RST;
    end else if (cfg_wr && (reg_idx == ksmh_pkg::REG_K_RANK)) begin
      k_rank_q <= pwdata[ksmh_pkg::K_RANK_W-1:0];
    end
  end

  assign prdata = (reg_idx == ksmh_pkg::REG_K_RANK) ? 32'(k_rank_q) : '0;

  assign in_value = signed'(s_axis_tdata[DATA_WIDTH-1:0]);

  ksmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ksmh_dp #(
    .K_MAX      (K_MAX),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .k_rank_i    (k_rank_q),
    .in_value_i  (in_value),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kth_o   (out_kth),
    .out_vres_o  (m_axis_tuser)
  );

  assign m_axis_tdata = TDW'($unsigned(out_kth));

  // A taken beat always moves the FSM out of idle, so the input is closed in the cycle after it.
  `KSMH_ASSERT(a_busy_after_beat, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input open right after a beat")

  // A result is only loaded when the output register is free.
  `KSMH_ASSERT(a_emit_free, cmd.emit |-> (!m_axis_tvalid || m_axis_tready), "result overwrote a waiting beat")

  // At most one datapath step per cycle.
  `KSMH_ASSERT(a_one_step, $onehot0({cmd.load, cmd.up_rd, cmd.up_cmp, cmd.dn_rd, cmd.dn_cmp, cmd.emit}), "overlapping datapath steps")

  // Output beat rises only from an emit step.
  `KSMH_ASSERT(a_valid_src, $rose(m_axis_tvalid) |-> $past(cmd.emit), "output valid without emit")

endmodule

`default_nettype wire
